// File: hdl/mmba_pkg.sv
// Shared types and constants for the block pair accumulator.
package mmba_pkg;

  localparam int LANES = 4;
  localparam int SUMS  = 2 * LANES;

  typedef logic [31:0] word_t;
  typedef logic [63:0] dword_t;
  typedef word_t  [LANES-1:0] lanes_t;
  typedef dword_t [SUMS-1:0]  sums_t;

  typedef struct packed {
    logic load_xy;
    logic load_uv;
    logic load_mul;
  } pipe_ctl_t;

  typedef struct packed {
    logic add;
    logic last;
  } acc_ctl_t;

endpackage

// File: hdl/multimixer_block_pair_accumulate_top.sv
// Top level of the block pair accumulator.
//
// The input channel takes one word per cycle unless stalled: a pair of 128-bit
// message blocks, their two key masks and a flag that marks the last pair of a
// message. Every pair is added into eight 64-bit accumulators. On the last
// pair the eight sums leave on the output channel as one tag word and the
// accumulators clear, so the next word starts a new message.
// The pipeline is five registers deep: input register, masked words, derived
// words, products, accumulators with the tag register.
// One word is accepted every cycle while in_ready is high; the eight lane
// multipliers and the accumulator adders each take one word per unstalled cycle.
// Reset clears the accumulators and all stage valid flags, and the block
// can accept a word in the first cycle after reset.
// When the receiver stalls, the tag register holds its word. Pairs that are
// not last keep flowing into the accumulators; only a second last pair
// waits in the product stage, and the stages behind it fill before in_ready
// falls.
module multimixer_block_pair_accumulate_top
  import mmba_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  dword_t in_block_x_low,
  input  dword_t in_block_x_high,
  input  dword_t in_block_y_low,
  input  dword_t in_block_y_high,
  input  dword_t in_mask_x_low,
  input  dword_t in_mask_x_high,
  input  dword_t in_mask_y_low,
  input  dword_t in_mask_y_high,
  input  logic   in_last_pair,
  output logic   out_valid,
  input  logic   out_ready,
  output dword_t out_sum_xy0,
  output dword_t out_sum_xy1,
  output dword_t out_sum_xy2,
  output dword_t out_sum_xy3,
  output dword_t out_sum_uv0,
  output dword_t out_sum_uv1,
  output dword_t out_sum_uv2,
  output dword_t out_sum_uv3
);

  logic [3:0] valid_r, valid_nxt;
  logic [3:0] last_r, last_nxt;
  logic [3:0] go;
  lanes_t     blk_x_r, blk_y_r, msk_x_r, msk_y_r;
  lanes_t     x_w, y_w, u_w, v_w;
  sums_t      prod, tag;
  pipe_ctl_t  pipe_ctl;
  acc_ctl_t   acc_ctl;

  always_comb begin
    go[3] = !valid_r[3] || !(last_r[3] && out_valid && !out_ready);
    go[2] = !valid_r[2] || go[3];
    go[1] = !valid_r[1] || go[2];
    go[0] = !valid_r[0] || go[1];
    in_ready = go[0];

    valid_nxt = valid_r;
    last_nxt  = last_r;
    if (go[0]) begin
      valid_nxt[0] = in_valid;
      last_nxt[0]  = in_last_pair;
    end
    for (int s = 1; s < 4; s++) begin
      if (go[s]) begin
        valid_nxt[s] = valid_r[s-1];
        last_nxt[s]  = last_r[s-1];
      end
    end

    pipe_ctl.load_xy  = go[1] && valid_r[0];
    pipe_ctl.load_uv  = go[2] && valid_r[1];
    pipe_ctl.load_mul = go[3] && valid_r[2];
    acc_ctl.add       = go[3] && valid_r[3];
    acc_ctl.last      = last_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      last_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go[0] && in_valid) begin
      blk_x_r <= {in_block_x_high, in_block_x_low};
      blk_y_r <= {in_block_y_high, in_block_y_low};
      msk_x_r <= {in_mask_x_high, in_mask_x_low};
      msk_y_r <= {in_mask_y_high, in_mask_y_low};
    end
  end

  mmba_mix u_mix (
    .clk   (clk),
    .ctl   (pipe_ctl),
    .blk_x (blk_x_r),
    .blk_y (blk_y_r),
    .msk_x (msk_x_r),
    .msk_y (msk_y_r),
    .x_out (x_w),
    .y_out (y_w),
    .u_out (u_w),
    .v_out (v_w)
  );

  mmba_mul u_mul (
    .clk  (clk),
    .ctl  (pipe_ctl),
    .x_in (x_w),
    .y_in (y_w),
    .u_in (u_w),
    .v_in (v_w),
    .prod (prod)
  );

  mmba_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (acc_ctl),
    .prod      (prod),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .tag       (tag)
  );

  assign out_sum_xy0 = tag[0];
  assign out_sum_xy1 = tag[1];
  assign out_sum_xy2 = tag[2];
  assign out_sum_xy3 = tag[3];
  assign out_sum_uv0 = tag[LANES];
  assign out_sum_uv1 = tag[LANES + 1];
  assign out_sum_uv2 = tag[LANES + 2];
  assign out_sum_uv3 = tag[LANES + 3];

endmodule

// File: hdl/mmba_mix.sv
// Key masking and derived word stages: X and Y, then U and V.
module mmba_mix
  import mmba_pkg::*;
(
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  lanes_t    blk_x,
  input  lanes_t    blk_y,
  input  lanes_t    msk_x,
  input  lanes_t    msk_y,
  output lanes_t    x_out,
  output lanes_t    y_out,
  output lanes_t    u_out,
  output lanes_t    v_out
);

  lanes_t x_r, y_r, x_nxt, y_nxt;
  lanes_t x2_r, y2_r, u_r, v_r, u_nxt, v_nxt;
  word_t  sx, sy;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      x_nxt[i] = blk_x[i] + msk_x[i];
      y_nxt[i] = blk_y[i] + msk_y[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_xy) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  always_comb begin
    sx = x_r[0] + x_r[1] + x_r[2] + x_r[3];
    sy = y_r[0] + y_r[1] + y_r[2] + y_r[3];
    for (int i = 0; i < LANES; i++) begin
      u_nxt[i] = sx - x_r[(i + LANES - 1) % LANES];
      v_nxt[i] = sy - y_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_uv) begin
      x2_r <= x_r;
      y2_r <= y_r;
      u_r  <= u_nxt;
      v_r  <= v_nxt;
    end
  end

  assign x_out = x2_r;
  assign y_out = y2_r;
  assign u_out = u_r;
  assign v_out = v_r;

endmodule

// File: hdl/mmba_mul.sv
// Eight 32x32 lane multipliers with registered products.
module mmba_mul
  import mmba_pkg::*;
(
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  lanes_t    x_in,
  input  lanes_t    y_in,
  input  lanes_t    u_in,
  input  lanes_t    v_in,
  output sums_t     prod
);

  sums_t prod_r, prod_nxt;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      prod_nxt[i]         = 64'(x_in[i]) * 64'(y_in[i]);
      prod_nxt[LANES + i] = 64'(u_in[i]) * 64'(v_in[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_mul) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

// File: hdl/mmba_acc.sv
// Product accumulators and the tag output register.
module mmba_acc
  import mmba_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  acc_ctl_t ctl,
  input  sums_t    prod,
  input  logic     out_ready,
  output logic     out_valid,
  output sums_t    tag
);

  sums_t acc_r, acc_nxt, sum;
  sums_t tag_r;
  logic  out_valid_r, out_valid_nxt;

  always_comb begin
    for (int i = 0; i < SUMS; i++) begin
      sum[i] = acc_r[i] + prod[i];
    end
    acc_nxt = acc_r;
    if (ctl.add) begin
      acc_nxt = ctl.last ? '0 : sum;
    end
    out_valid_nxt = out_valid_r;
    if (ctl.add && ctl.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.add && ctl.last) begin
      tag_r <= sum;
    end
  end

  assign out_valid = out_valid_r;
  assign tag       = tag_r;

endmodule

// File: hdl/mmba_checker.sv
// Port checker for the block pair accumulator and its bind statement.
module mmba_checker
  import mmba_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input dword_t out_sum_xy0,
  input dword_t out_sum_uv3
);

  // A stalled tag word keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sum_xy0) && $stable(out_sum_uv3))
    else $error("tag word changed while stalled");

  // With no tag waiting the pipeline never refuses a word.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with empty output register");

  // No tag can appear while the pipeline is still filling after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid ##1 !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("tag word too soon after reset");

endmodule

bind multimixer_block_pair_accumulate_top mmba_checker u_mmba_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_sum_xy0 (out_sum_xy0),
  .out_sum_uv3 (out_sum_uv3)
);

// File: bench/mmba_tb_pkg.sv
`timescale 1ns / 100ps
// Pair word type and tag scoreboard for the block pair accumulator bench.
package mmba_tb_pkg;
  import mmba_pkg::*;

  typedef struct {
    dword_t block_x_low;
    dword_t block_x_high;
    dword_t block_y_low;
    dword_t block_y_high;
    dword_t mask_x_low;
    dword_t mask_x_high;
    dword_t mask_y_low;
    dword_t mask_y_high;
    logic   last_pair;
  } pair_word_t;

  class tag_tracker;
    sums_t running;
    sums_t pending_tags[$];
    int    failures;
    int    pairs_absorbed;
    int    tags_checked;

    function new();
      running = '0;
      failures = 0;
      pairs_absorbed = 0;
      tags_checked = 0;
    endfunction

    function void absorb_pair(pair_word_t p);
      lanes_t bx, by, kx, ky;
      word_t  x[LANES];
      word_t  y[LANES];
      word_t  sx, sy, u, v;
      bx = {p.block_x_high, p.block_x_low};
      by = {p.block_y_high, p.block_y_low};
      kx = {p.mask_x_high, p.mask_x_low};
      ky = {p.mask_y_high, p.mask_y_low};
      sx = '0;
      sy = '0;
      for (int i = 0; i < LANES; i++) begin
        x[i] = bx[i] + kx[i];
        y[i] = by[i] + ky[i];
        sx += x[i];
        sy += y[i];
      end
      for (int i = 0; i < LANES; i++) begin
        u = sx - x[(i + 3) % LANES];
        v = sy - y[i];
        running[i] += dword_t'(x[i]) * dword_t'(y[i]);
        running[LANES + i] += dword_t'(u) * dword_t'(v);
      end
      pairs_absorbed++;
      if (p.last_pair) begin
        pending_tags.push_back(running);
        running = '0;
      end
    endfunction

    function void compare_tag(sums_t got);
      sums_t want;
      if (pending_tags.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("Tag word arrived with no message closed: %h", got);
        end
        return;
      end
      want = pending_tags.pop_front();
      tags_checked++;
      for (int i = 0; i < SUMS; i++) begin
        if (got[i] !== want[i]) begin
          failures++;
          if (failures <= 10) begin
            $display("Tag word %0d sum %0d: expected %h, got %h", tags_checked, i,
                     want[i], got[i]);
          end
        end
      end
    endfunction
  endclass

endpackage

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench top: drives block pair words and checks every tag word.
module tb_top;
  import mmba_pkg::*;
  import mmba_tb_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_PAIRS = 246;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  dword_t in_block_x_low = '0;
  dword_t in_block_x_high = '0;
  dword_t in_block_y_low = '0;
  dword_t in_block_y_high = '0;
  dword_t in_mask_x_low = '0;
  dword_t in_mask_x_high = '0;
  dword_t in_mask_y_low = '0;
  dword_t in_mask_y_high = '0;
  logic   in_last_pair = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  dword_t out_sum_xy0, out_sum_xy1, out_sum_xy2, out_sum_xy3;
  dword_t out_sum_uv0, out_sum_uv1, out_sum_uv2, out_sum_uv3;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;

  tag_tracker tracker = new();

  multimixer_block_pair_accumulate_top uut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        tracker.compare_tag({out_sum_uv3, out_sum_uv2, out_sum_uv1, out_sum_uv0,
                             out_sum_xy3, out_sum_xy2, out_sum_xy1, out_sum_xy0});
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic dword_t random_dword();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return {32'hFFFF_FFFF, 32'($urandom)};
      3: return {32'($urandom), 32'hFFFF_FFFF};
      4: return {32'h0, 32'($urandom)};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic pair_word_t random_pair(logic last);
    pair_word_t p;
    p.block_x_low = random_dword();
    p.block_x_high = random_dword();
    p.block_y_low = random_dword();
    p.block_y_high = random_dword();
    p.mask_x_low = random_dword();
    p.mask_x_high = random_dword();
    p.mask_y_low = random_dword();
    p.mask_y_high = random_dword();
    p.last_pair = last;
    return p;
  endfunction

  function automatic pair_word_t uniform_pair(dword_t value, logic last);
    pair_word_t p;
    p.block_x_low = value;
    p.block_x_high = value;
    p.block_y_low = value;
    p.block_y_high = value;
    p.mask_x_low = value;
    p.mask_x_high = value;
    p.mask_y_low = value;
    p.mask_y_high = value;
    p.last_pair = last;
    return p;
  endfunction

  task automatic send_pair(input pair_word_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_block_x_low <= p.block_x_low;
    in_block_x_high <= p.block_x_high;
    in_block_y_low <= p.block_y_low;
    in_block_y_high <= p.block_y_high;
    in_mask_x_low <= p.mask_x_low;
    in_mask_x_high <= p.mask_x_high;
    in_mask_y_low <= p.mask_y_low;
    in_mask_y_high <= p.mask_y_high;
    in_last_pair <= p.last_pair;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    tracker.absorb_pair(p);
  endtask

  task automatic run_random_phase(input int send_pct, input int recv_pct);
    int sent;
    int pairs;
    sent = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < PHASE_PAIRS) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: pairs = $urandom_range(1, 4);
        6, 7, 8: pairs = $urandom_range(5, 12);
        default: pairs = $urandom_range(13, 40);
      endcase
      for (int k = 0; k < pairs; k++) begin
        send_pair(random_pair(k == pairs - 1));
      end
      sent += pairs;
    end
  endtask

  initial begin
    pair_word_t p;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 7;
    recv_idle_pct = 61;

    send_pair(uniform_pair('0, 1'b1));
    send_pair(uniform_pair('1, 1'b1));
    // A long message of maximal words wraps every accumulator.
    repeat (3) send_pair(uniform_pair('1, 1'b0));
    send_pair(uniform_pair('1, 1'b1));
    p = uniform_pair('1, 1'b1);
    p.mask_x_low = {2{32'h1}};
    p.mask_x_high = {2{32'h1}};
    send_pair(p);
    p = uniform_pair('0, 1'b1);
    p.block_x_low = {2{32'h8000_0000}};
    p.block_x_high = {2{32'h8000_0000}};
    p.block_y_low = {2{32'h8000_0000}};
    p.block_y_high = {2{32'h8000_0000}};
    send_pair(p);
    p = uniform_pair('0, 1'b0);
    p.block_x_low = 64'd1;
    p.block_y_low = 64'd1;
    send_pair(p);
    p = uniform_pair('0, 1'b1);
    p.mask_x_high = 64'h1_0000_0000;
    p.mask_y_high = 64'h1_0000_0000;
    send_pair(p);
    p = random_pair(1'b1);
    p.block_x_low = '0;
    p.block_x_high = '0;
    p.block_y_low = '0;
    p.block_y_high = '0;
    send_pair(p);
    p = random_pair(1'b1);
    p.mask_x_low = '0;
    p.mask_x_high = '0;
    p.mask_y_low = '0;
    p.mask_y_high = '0;
    send_pair(p);

    run_random_phase(7, 61);
    run_random_phase(61, 7);
    run_random_phase(0, 0);

    in_valid <= 1'b0;
    while (tracker.pending_tags.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d block pairs and checked %0d tag words under receiver-heavy,",
             tracker.pairs_absorbed, tracker.tags_checked);
    $display("sender-heavy and stall-free traffic; %0d mismatches.", tracker.failures);
    if (tracker.failures == 0 && tracker.pending_tags.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
